// File: rtl/quad_motor_mixer_attitude_control_top_macros.svh
// Assertion macros shared by the motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_ATTITUDE_CONTROL_TOP_MACROS_SVH
`define QUAD_MOTOR_MIXER_ATTITUDE_CONTROL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define QMM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("qmm assertion failed");
// Checked at every edge, reset included.
`define QMM_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("qmm assertion failed");
`else
`define QMM_ASSERT(label, prop)
`define QMM_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/qmm_pkg.sv
// Package: constants, register indexes, types and helper functions of the motor mixer.
`timescale 1ns / 1ps
`default_nettype none
package qmm_pkg;

   localparam int ATTITUDE_MAG_SHIFT      = 8;
   localparam int YAW_MAG_SHIFT           = 7;
   localparam int RATE_SHIFT              = 0;
   localparam int ANGLE_SHIFT             = 0;
   localparam int ATTITUDE_SETPOINT_SHIFT = 3;
   localparam int YAW_SETPOINT_SHIFT      = 3;
   localparam int HEIGHT_SHIFT            = 3;
   localparam int CTRL_LIMIT              = 32767;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] OP_MANUAL  = 3'd0;
   localparam logic [2:0] OP_YAW     = 3'd1;
   localparam logic [2:0] OP_FULL    = 3'd2;
   localparam logic [2:0] OP_HEIGHT  = 3'd3;
   localparam logic [2:0] OP_CAPTURE = 3'd4;

   localparam logic [2:0] REG_YAW_GAIN         = 3'd0;
   localparam logic [2:0] REG_ROLL_ANGLE_GAIN  = 3'd1;
   localparam logic [2:0] REG_ROLL_RATE_GAIN   = 3'd2;
   localparam logic [2:0] REG_PITCH_ANGLE_GAIN = 3'd3;
   localparam logic [2:0] REG_PITCH_RATE_GAIN  = 3'd4;
   localparam logic [2:0] REG_HEIGHT_GAIN      = 3'd5;
   localparam logic [2:0] REG_RUN_FLOOR        = 3'd6;
   localparam logic [2:0] REG_RUN_CEILING      = 3'd7;

   localparam logic signed [33:0] SAT_HI = 34'(CTRL_LIMIT);
   localparam logic signed [33:0] SAT_LO = -34'(CTRL_LIMIT);

   typedef enum logic [2:0] {
      MODE_MANUAL,
      MODE_YAW,
      MODE_FULL,
      MODE_HEIGHT,
      MODE_OFF
   } qmm_mode_type;

   typedef struct packed {
      logic [14:0] yaw_gain;
      logic [14:0] roll_angle_gain;
      logic [14:0] roll_rate_gain;
      logic [14:0] pitch_angle_gain;
      logic [14:0] pitch_rate_gain;
      logic [14:0] height_gain;
      logic [9:0]  run_floor;
      logic [9:0]  run_ceiling;
   } qmm_cfg_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] roll_setpoint;
      logic signed [15:0] pitch_setpoint;
      logic signed [15:0] yaw_setpoint;
      logic signed [15:0] lift_stick;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] yaw_rate;
      logic [19:0]        baro_pressure;
   } qmm_item_type;

   typedef struct packed {
      qmm_mode_type       mode;
      logic [9:0]         base;
      logic signed [15:0] press_err;
      logic signed [16:0] roll_err;
      logic signed [16:0] pitch_err;
      logic signed [16:0] yaw_err;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] roll_sp;
      logic signed [15:0] pitch_sp;
      logic signed [15:0] yaw_sp;
   } qmm_stage1_type;

   typedef struct packed {
      qmm_mode_type       mode;
      logic [9:0]         base;
      logic signed [31:0] height_prod;
      logic signed [32:0] roll_p1;
      logic signed [31:0] roll_p2;
      logic signed [32:0] pitch_p1;
      logic signed [31:0] pitch_p2;
      logic signed [32:0] yaw_prod;
      logic signed [15:0] roll_sp;
      logic signed [15:0] pitch_sp;
      logic signed [15:0] yaw_sp;
   } qmm_stage2_type;

   typedef struct packed {
      logic [9:0] front;
      logic [9:0] right;
      logic [9:0] back;
      logic [9:0] left;
   } qmm_motor_type;

   // Clip a control law to +-CTRL_LIMIT.
   function automatic logic signed [15:0] qmm_sat(input logic signed [33:0] x);
      if (x > SAT_HI) begin
         return 16'(SAT_HI);
      end else if (x < SAT_LO) begin
         return 16'(SAT_LO);
      end
      return 16'(x);
   endfunction

   // Magnitude; -32768 maps to 32768.
   function automatic logic [15:0] qmm_abs(input logic signed [15:0] c);
      if (c[15]) begin
         return 16'(~c) + 16'd1;
      end
      return 16'(c);
   endfunction

endpackage
`default_nettype wire

// File: rtl/qmm_if.sv
// Request and response channel interfaces of the motor mixer.
`timescale 1ns / 1ps
`default_nettype none
interface qmm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [15:0] roll_setpoint;
   logic signed [15:0] pitch_setpoint;
   logic signed [15:0] yaw_setpoint;
   logic signed [15:0] lift_stick;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] roll_rate;
   logic signed [15:0] pitch_rate;
   logic signed [15:0] yaw_rate;
   logic [19:0]        baro_pressure;

   modport source (
      output valid, opcode, roll_setpoint, pitch_setpoint, yaw_setpoint, lift_stick,
             roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate, baro_pressure,
      input  ready
   );
   modport sink (
      input  valid, opcode, roll_setpoint, pitch_setpoint, yaw_setpoint, lift_stick,
             roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate, baro_pressure,
      output ready
   );
endinterface

interface qmm_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] motor_front;
   logic [9:0] motor_right;
   logic [9:0] motor_back;
   logic [9:0] motor_left;

   modport source (
      output valid, motor_front, motor_right, motor_back, motor_left,
      input  ready
   );
   modport sink (
      input  valid, motor_front, motor_right, motor_back, motor_left,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/quad_motor_mixer_attitude_control_top.sv
// Top level of the quadcopter motor mixer with cascaded P attitude control.
//
// req_if carries one beat per control step: mode opcode, stick setpoints,
// attitude angles, body rates and barometric pressure. rsp_if returns one
// beat with four motor commands for every request beat, in order.
// Gains and speed limits sit in an APB-style register file (psel/penable,
// byte address 4*index, pready always high); write them only while no
// request is in flight.
// The datapath is a three-register pipeline: input decode, gain products,
// mix and clamp. Throughput is one beat per cycle while the response is
// taken; a low rsp_if.ready stalls it.
// When rsp_if.ready is low the response holds and the pipeline fills;
// req_if.ready drops once all three stages hold a beat.
// Synchronous reset empties the pipeline, restores the register defaults
// and clears the captured lift and pressure setpoint.
`timescale 1ns / 1ps
`default_nettype none
`include "quad_motor_mixer_attitude_control_top_macros.svh"
module quad_motor_mixer_attitude_control_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   qmm_req_if.sink                              req_if,
   qmm_rsp_if.source                            rsp_if,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [qmm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [qmm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [qmm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import qmm_pkg::*;

   qmm_cfg_type    cfg;
   qmm_item_type   item;
   qmm_stage1_type s1;
   qmm_stage2_type s2;
   qmm_motor_type  motors;
   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic           s2_valid_ff;
   logic           s2_valid_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           out_adv;
   logic           s2_adv;
   logic           s1_adv;
   logic           accept;
   logic           pipe_full;
   logic           motors_capped;

   assign item.opcode         = req_if.opcode;
   assign item.roll_setpoint  = req_if.roll_setpoint;
   assign item.pitch_setpoint = req_if.pitch_setpoint;
   assign item.yaw_setpoint   = req_if.yaw_setpoint;
   assign item.lift_stick     = req_if.lift_stick;
   assign item.roll_angle     = req_if.roll_angle;
   assign item.pitch_angle    = req_if.pitch_angle;
   assign item.roll_rate      = req_if.roll_rate;
   assign item.pitch_rate     = req_if.pitch_rate;
   assign item.yaw_rate       = req_if.yaw_rate;
   assign item.baro_pressure  = req_if.baro_pressure;

   // A stage advances when it is empty or the stage after it advances.
   assign out_adv = !out_valid_ff || rsp_if.ready;
   assign s2_adv  = !s2_valid_ff || out_adv;
   assign s1_adv  = !s1_valid_ff || s2_adv;
   assign accept  = req_if.valid && s1_adv;

   assign req_if.ready       = s1_adv;
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.motor_front = motors.front;
   assign rsp_if.motor_right = motors.right;
   assign rsp_if.motor_back  = motors.back;
   assign rsp_if.motor_left  = motors.left;

   assign pipe_full     = out_valid_ff && s2_valid_ff && s1_valid_ff;
   assign motors_capped = (motors.front <= cfg.run_ceiling) && (motors.right <= cfg.run_ceiling)
                       && (motors.back <= cfg.run_ceiling) && (motors.left <= cfg.run_ceiling);

   always_comb begin
      s1_valid_in  = s1_adv ? req_if.valid : s1_valid_ff;
      s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_adv ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   qmm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qmm_prep u_prep (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .s1     (s1)
   );

   qmm_mult u_mult (
      .clock (clock),
      .load  (s2_adv && s1_valid_ff),
      .cfg   (cfg),
      .s1    (s1),
      .s2    (s2)
   );

   qmm_mix u_mix (
      .clock  (clock),
      .load   (out_adv && s2_valid_ff),
      .cfg    (cfg),
      .s2     (s2),
      .motors (motors)
   );

   `QMM_ASSERT(a_accept_fills_s1, accept |=> s1_valid_ff)
   `QMM_ASSERT(a_full_stall_blocks, (pipe_full && !rsp_if.ready) |-> !req_if.ready)
   `QMM_ASSERT(a_rsp_from_s2, $rose(out_valid_ff) |-> $past(s2_valid_ff))
   `QMM_ASSERT(a_motor_limit, out_valid_ff |-> motors_capped)
   `QMM_ASSERT_ALWAYS(a_reset_empties, reset |=> (!out_valid_ff && !s2_valid_ff && !s1_valid_ff))
endmodule
`default_nettype wire

// File: rtl/qmm_csr.sv
// APB-style configuration registers of the motor mixer.
`timescale 1ns / 1ps
`default_nettype none
module qmm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [qmm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [qmm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [qmm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output qmm_pkg::qmm_cfg_type                 cfg
);
   import qmm_pkg::*;

   qmm_cfg_type cfg_ff;
   qmm_cfg_type cfg_in;
   logic [2:0]  reg_index;
   logic        wr_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_YAW_GAIN:         cfg_in.yaw_gain         = pwdata[14:0];
            REG_ROLL_ANGLE_GAIN:  cfg_in.roll_angle_gain  = pwdata[14:0];
            REG_ROLL_RATE_GAIN:   cfg_in.roll_rate_gain   = pwdata[14:0];
            REG_PITCH_ANGLE_GAIN: cfg_in.pitch_angle_gain = pwdata[14:0];
            REG_PITCH_RATE_GAIN:  cfg_in.pitch_rate_gain  = pwdata[14:0];
            REG_HEIGHT_GAIN:      cfg_in.height_gain      = pwdata[14:0];
            REG_RUN_FLOOR:        cfg_in.run_floor        = pwdata[9:0];
            REG_RUN_CEILING:      cfg_in.run_ceiling      = pwdata[9:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_YAW_GAIN:         prdata = CSR_DATA_W'(cfg_ff.yaw_gain);
         REG_ROLL_ANGLE_GAIN:  prdata = CSR_DATA_W'(cfg_ff.roll_angle_gain);
         REG_ROLL_RATE_GAIN:   prdata = CSR_DATA_W'(cfg_ff.roll_rate_gain);
         REG_PITCH_ANGLE_GAIN: prdata = CSR_DATA_W'(cfg_ff.pitch_angle_gain);
         REG_PITCH_RATE_GAIN:  prdata = CSR_DATA_W'(cfg_ff.pitch_rate_gain);
         REG_HEIGHT_GAIN:      prdata = CSR_DATA_W'(cfg_ff.height_gain);
         REG_RUN_FLOOR:        prdata = CSR_DATA_W'(cfg_ff.run_floor);
         REG_RUN_CEILING:      prdata = CSR_DATA_W'(cfg_ff.run_ceiling);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_gain         <= 15'd8;
         cfg_ff.roll_angle_gain  <= 15'd10;
         cfg_ff.roll_rate_gain   <= 15'd20;
         cfg_ff.pitch_angle_gain <= 15'd10;
         cfg_ff.pitch_rate_gain  <= 15'd20;
         cfg_ff.height_gain      <= 15'd1;
         cfg_ff.run_floor        <= 10'd180;
         cfg_ff.run_ceiling      <= 10'd800;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/qmm_prep.sv
// Input stage: mode decode, height setpoint state, lift base and error terms.
`timescale 1ns / 1ps
`default_nettype none
module qmm_prep (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire qmm_pkg::qmm_item_type   item,
   output qmm_pkg::qmm_stage1_type      s1
);
   import qmm_pkg::*;

   logic signed [15:0] held_lift_ff;
   logic signed [15:0] held_lift_in;
   logic [19:0]        held_pressure_ff;
   logic [19:0]        held_pressure_in;
   qmm_stage1_type     s1_ff;
   qmm_stage1_type     s1_in;
   logic signed [15:0] lift_eff;
   logic [19:0]        press_ref;
   logic signed [20:0] press_diff;
   logic               capture;

   assign capture = (item.opcode == OP_CAPTURE);
   assign s1      = s1_ff;

   always_comb begin
      held_lift_in     = held_lift_ff;
      held_pressure_in = held_pressure_ff;
      if (accept && capture) begin
         held_lift_in     = item.lift_stick;
         held_pressure_in = item.baro_pressure;
      end
   end

   always_comb begin
      // Height hold reads the stored setpoint; capture uses this beat's values.
      lift_eff   = (item.opcode == OP_HEIGHT) ? held_lift_ff : item.lift_stick;
      press_ref  = capture ? item.baro_pressure : held_pressure_ff;
      press_diff = $signed({1'b0, press_ref}) - $signed({1'b0, item.baro_pressure});

      unique case (item.opcode) inside
         OP_MANUAL:             s1_in.mode = MODE_MANUAL;
         OP_YAW:                s1_in.mode = MODE_YAW;
         OP_FULL:               s1_in.mode = MODE_FULL;
         OP_HEIGHT, OP_CAPTURE: s1_in.mode = MODE_HEIGHT;
         default:               s1_in.mode = MODE_OFF;
      endcase

      // (lift + 32768) >> 6
      s1_in.base       = {~lift_eff[15], lift_eff[14:6]};
      s1_in.press_err  = qmm_sat(34'(press_diff));
      s1_in.roll_err   = 17'(item.roll_setpoint >>> ATTITUDE_SETPOINT_SHIFT)
                       - 17'(item.roll_angle >>> ANGLE_SHIFT);
      s1_in.pitch_err  = 17'(item.pitch_setpoint >>> ATTITUDE_SETPOINT_SHIFT)
                       - 17'(item.pitch_angle >>> ANGLE_SHIFT);
      s1_in.yaw_err    = 17'(item.yaw_setpoint >>> YAW_SETPOINT_SHIFT)
                       - 17'(item.yaw_rate);
      s1_in.roll_rate  = item.roll_rate >>> RATE_SHIFT;
      s1_in.pitch_rate = item.pitch_rate >>> RATE_SHIFT;
      s1_in.roll_sp    = item.roll_setpoint;
      s1_in.pitch_sp   = item.pitch_setpoint;
      s1_in.yaw_sp     = item.yaw_setpoint;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lift_ff     <= '0;
         held_pressure_ff <= '0;
      end else begin
         held_lift_ff     <= held_lift_in;
         held_pressure_ff <= held_pressure_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/qmm_mult.sv
// Gain stage: the six gain products, registered.
`timescale 1ns / 1ps
`default_nettype none
module qmm_mult (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire qmm_pkg::qmm_cfg_type     cfg,
   input  wire qmm_pkg::qmm_stage1_type  s1,
   output qmm_pkg::qmm_stage2_type       s2
);
   import qmm_pkg::*;

   qmm_stage2_type s2_ff;
   qmm_stage2_type s2_in;

   assign s2 = s2_ff;

   always_comb begin
      s2_in.mode        = s1.mode;
      s2_in.base        = s1.base;
      s2_in.height_prod = $signed({1'b0, cfg.height_gain}) * s1.press_err;
      s2_in.roll_p1     = $signed({1'b0, cfg.roll_angle_gain}) * s1.roll_err;
      s2_in.roll_p2     = $signed({1'b0, cfg.roll_rate_gain}) * s1.roll_rate;
      s2_in.pitch_p1    = $signed({1'b0, cfg.pitch_angle_gain}) * s1.pitch_err;
      s2_in.pitch_p2    = $signed({1'b0, cfg.pitch_rate_gain}) * s1.pitch_rate;
      s2_in.yaw_prod    = $signed({1'b0, cfg.yaw_gain}) * s1.yaw_err;
      s2_in.roll_sp     = s1.roll_sp;
      s2_in.pitch_sp    = s1.pitch_sp;
      s2_in.yaw_sp      = s1.yaw_sp;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_ff <= s2_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/qmm_mix.sv
// Mix stage: saturate laws, plus-configuration mix into four motors, floor and clamp, registered.
`timescale 1ns / 1ps
`default_nettype none
module qmm_mix (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire qmm_pkg::qmm_cfg_type     cfg,
   input  wire qmm_pkg::qmm_stage2_type  s2,
   output qmm_pkg::qmm_motor_type        motors
);
   import qmm_pkg::*;

   qmm_motor_type      motors_ff;
   qmm_motor_type      motors_in;
   logic signed [15:0] roll_c;
   logic signed [15:0] pitch_c;
   logic signed [15:0] yaw_c;
   logic signed [31:0] roll_t;
   logic signed [31:0] pitch_t;
   logic signed [31:0] yaw_t;
   logic signed [31:0] height_d;
   logic signed [31:0] level;
   logic               manual_att;
   logic               run;

   // Floor at min, then clamp at max; a crossed pair ends at max.
   function automatic logic [9:0] limit(input logic signed [31:0] ae,
                                        input logic [9:0] lo,
                                        input logic [9:0] hi);
      logic signed [31:0] fl;
      fl = (ae < $signed(32'(lo))) ? $signed(32'(lo)) : ae;
      if (fl > $signed(32'(hi))) begin
         return hi;
      end
      return fl[9:0];
   endfunction

   function automatic logic signed [31:0] term(input logic signed [15:0] c,
                                               input logic [15:0] m);
      logic signed [31:0] t;
      t = $signed(32'(m));
      return c[15] ? -t : t;
   endfunction

   assign motors = motors_ff;

   always_comb begin
      manual_att = (s2.mode == MODE_MANUAL) || (s2.mode == MODE_YAW);
      roll_c     = manual_att ? s2.roll_sp
                              : qmm_sat(34'(s2.roll_p1) - 34'(s2.roll_p2));
      pitch_c    = manual_att ? s2.pitch_sp
                              : qmm_sat(34'(s2.pitch_p1) - 34'(s2.pitch_p2));
      yaw_c      = (s2.mode == MODE_MANUAL) ? s2.yaw_sp : qmm_sat(34'(s2.yaw_prod));

      roll_t  = term(roll_c, qmm_abs(roll_c) >> ATTITUDE_MAG_SHIFT);
      pitch_t = term(pitch_c, qmm_abs(pitch_c) >> ATTITUDE_MAG_SHIFT);
      yaw_t   = term(yaw_c, qmm_abs(yaw_c) >> YAW_MAG_SHIFT);

      height_d = (s2.mode == MODE_HEIGHT) ? (s2.height_prod >>> HEIGHT_SHIFT) : 32'sd0;
      level    = $signed(32'(s2.base)) - height_d;

      // Lift check is made on the base, before the height term.
      run = (s2.mode != MODE_OFF) && (s2.base >= cfg.run_floor);

      motors_in = '0;
      if (run) begin
         motors_in.front = limit(level + pitch_t - yaw_t, cfg.run_floor, cfg.run_ceiling);
         motors_in.right = limit(level - roll_t + yaw_t, cfg.run_floor, cfg.run_ceiling);
         motors_in.back  = limit(level - pitch_t - yaw_t, cfg.run_floor, cfg.run_ceiling);
         motors_in.left  = limit(level + roll_t + yaw_t, cfg.run_floor, cfg.run_ceiling);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         motors_ff <= motors_in;
      end
   end
endmodule
`default_nettype wire
